@@ src/stt_pkg.sv @@
// Shared types, token kind codes and character classes for the source text tokenizer.
package stt_pkg;

  // Position counter width and the number of identifier bytes kept for keyword matching.
  localparam int unsigned POS_BITS      = 16;
  localparam int unsigned KW_CHARS      = 6;
  localparam int unsigned KW_IDX_W      = $clog2(KW_CHARS);
  localparam int unsigned KW_COUNT      = 6;
  localparam int unsigned KW_TEXT_CHARS = 6;

  // Result queue between the scanner and the output channel.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // Token kinds.
  localparam logic [4:0] KIND_IDENT  = 5'd0;
  localparam logic [4:0] KIND_TYPE   = 5'd1;
  localparam logic [4:0] KIND_KW_IF  = 5'd2;
  localparam logic [4:0] KIND_INT    = 5'd8;
  localparam logic [4:0] KIND_SEMI   = 5'd9;
  localparam logic [4:0] KIND_LPAREN = 5'd10;
  localparam logic [4:0] KIND_RPAREN = 5'd11;
  localparam logic [4:0] KIND_LBRACE = 5'd12;
  localparam logic [4:0] KIND_RBRACE = 5'd13;
  localparam logic [4:0] KIND_LBRACK = 5'd14;
  localparam logic [4:0] KIND_RBRACK = 5'd15;
  localparam logic [4:0] KIND_COMMA  = 5'd16;
  localparam logic [4:0] KIND_PLUS   = 5'd17;
  localparam logic [4:0] KIND_STAR   = 5'd18;
  localparam logic [4:0] KIND_SLASH  = 5'd19;
  localparam logic [4:0] KIND_BANG   = 5'd20;
  localparam logic [4:0] KIND_AMP    = 5'd21;
  localparam logic [4:0] KIND_AT     = 5'd22;
  localparam logic [4:0] KIND_DOT    = 5'd23;
  localparam logic [4:0] KIND_LESS   = 5'd24;
  localparam logic [4:0] KIND_GREAT  = 5'd25;
  localparam logic [4:0] KIND_ASSIGN = 5'd26;
  localparam logic [4:0] KIND_EQUALS = 5'd27;
  localparam logic [4:0] KIND_MINUS  = 5'd28;
  localparam logic [4:0] KIND_ARROW  = 5'd29;
  localparam logic [4:0] KIND_EOF    = 5'd30;
  localparam logic [4:0] KIND_ERROR  = 5'd31;

  // Keyword spellings in order if, else, while, for, ret, struct, padded with zero bytes.
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_TEXT_CHARS] = '{
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00},
    '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00},
    '{8'h66, 8'h6f, 8'h72, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00},
    '{8'h73, 8'h74, 8'h72, 8'h75, 8'h63, 8'h74}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd5, 3'd3, 3'd3, 3'd6};

  typedef logic [KW_CHARS-1:0][7:0] prefix_t;

  // One result item as it waits in the output queue.
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5a);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h0a) || (c == 8'h09);
  endfunction

  // Single-character punctuation; returns a hit flag and the kind.
  function automatic logic [5:0] punct_lookup(input logic [7:0] c);
    logic [4:0] k;
    logic       hit;
    hit = 1'b1;
    case (c)
      8'h3b:   k = KIND_SEMI;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7b:   k = KIND_LBRACE;
      8'h7d:   k = KIND_RBRACE;
      8'h5b:   k = KIND_LBRACK;
      8'h5d:   k = KIND_RBRACK;
      8'h2c:   k = KIND_COMMA;
      8'h2b:   k = KIND_PLUS;
      8'h2a:   k = KIND_STAR;
      8'h2f:   k = KIND_SLASH;
      8'h21:   k = KIND_BANG;
      8'h26:   k = KIND_AMP;
      8'h40:   k = KIND_AT;
      8'h2e:   k = KIND_DOT;
      8'h3c:   k = KIND_LESS;
      8'h3e:   k = KIND_GREAT;
      default: begin
        k   = KIND_IDENT;
        hit = 1'b0;
      end
    endcase
    return {hit, k};
  endfunction

  // Kind of a finished identifier: type, keyword or plain identifier.
  function automatic logic [4:0] ident_kind(input prefix_t prefix, input logic [15:0] len,
                                            input logic upper);
    logic [4:0] k;
    logic       match;
    logic [7:0] ref_ch;
    k = KIND_IDENT;
    for (int w = KW_COUNT - 1; w >= 0; w--) begin
      match = (len == 16'(KW_LEN[w]));
      for (int i = 0; i < KW_CHARS; i++) begin
        ref_ch = (i < KW_TEXT_CHARS) ? KW_TEXT[w][i] : 8'h00;
        if (prefix[i] != ref_ch) match = 1'b0;
      end
      if (match) k = KIND_KW_IF + 5'(w);
    end
    if (upper) k = KIND_TYPE;
    return k;
  endfunction

endpackage

@@ src/stt_if.sv @@
// Channel interfaces: source bytes in, tokens out.
interface stt_char_if;
  import stt_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface stt_token_if;
  import stt_pkg::*;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_step;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output last_of_step, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input last_of_step, output ready);
endinterface

@@ src/source_text_tokenizer.sv @@
// Streaming tokenizer: scanner state machine with a small result queue.
//
//   channel   dir   payload                                            transfer
//   char_i    in    char_code                                          valid & ready
//   token_o   out   token_kind, token_start, token_length, last_of_step valid & ready
//
// One byte is scanned in the cycle it is transferred; its results enter a four-entry
// queue and appear on token_o in order, behind any results already waiting.
// A byte is taken every cycle while the queue holds at most two results, so a byte stream
// runs at one byte per cycle except where bytes that close a token give two results each
// and fill the queue faster than token_o drains it.
// A stall on token_o fills the queue and then holds char_i off.
// Reset clears the scanner to idle at position zero and empties the queue.
module source_text_tokenizer
  import stt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  stt_char_if.sink    char_i,
  stt_token_if.source token_o
);

  localparam logic [2:0] MODE_IDLE       = 3'd0;
  localparam logic [2:0] MODE_IDENT      = 3'd1;
  localparam logic [2:0] MODE_INT        = 3'd2;
  localparam logic [2:0] MODE_HOLD_EQ    = 3'd3;
  localparam logic [2:0] MODE_HOLD_MINUS = 3'd4;
  localparam logic [2:0] MODE_HALTED     = 3'd5;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  logic [2:0]          mode_q, mode_d;
  logic [POS_BITS-1:0] pos_q, pos_d, pos_inc;
  logic [15:0]         pstart_q, pstart_d;
  logic [15:0]         plen_q, plen_d, plen_inc;
  prefix_t             prefix_q, prefix_d;
  logic                upper_q, upper_d;

  token_t              fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wptr_q, rptr_q;
  logic [FIFO_CW-1:0]  cnt_q;

  logic                in_xfer, out_xfer;
  logic [7:0]          c;
  logic [15:0]         pos16;
  logic                fall, has_new, hold_eq;
  logic [5:0]          punct;
  token_t              tok_new, res0, res1;
  logic [1:0]          n_res;

  assign in_xfer  = char_i.valid && char_i.ready;
  assign out_xfer = token_o.valid && token_o.ready;
  assign c        = char_i.char_code;
  assign pos16    = 16'(pos_q);
  assign pos_inc  = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
  assign plen_inc = (plen_q == LEN_MAX) ? plen_q : plen_q + 16'd1;
  assign punct    = punct_lookup(c);
  assign hold_eq  = (mode_q == MODE_HOLD_EQ);

  // Scanner: next state and up to two results for the byte in transfer.
  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    prefix_d = prefix_q;
    upper_d  = upper_q;
    res0     = '0;
    res1     = '0;
    tok_new  = '0;
    n_res    = 2'd0;
    fall     = 1'b0;
    has_new  = 1'b0;

    if (in_xfer) begin
      // Close or extend whatever token is pending.
      unique case (mode_q) inside
        MODE_HALTED: begin
          if (c == 8'h00) begin
            mode_d = MODE_IDLE;
            pos_d  = '0;
          end else begin
            pos_d = pos_inc;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(c) || c == 8'h5f || c == 8'h40) begin
            if (plen_q < 16'(KW_CHARS)) prefix_d[plen_q[KW_IDX_W-1:0]] = c;
            plen_d = plen_inc;
            pos_d  = pos_inc;
          end else begin
            res0  = '{kind: ident_kind(prefix_q, plen_q, upper_q), start: pstart_q,
                      length: plen_q, last: 1'b0};
            n_res = 2'd1;
            fall  = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(c)) begin
            plen_d = plen_inc;
            pos_d  = pos_inc;
          end else begin
            res0  = '{kind: KIND_INT, start: pstart_q, length: plen_q, last: 1'b0};
            n_res = 2'd1;
            fall  = 1'b1;
          end
        end
        MODE_HOLD_EQ, MODE_HOLD_MINUS: begin
          n_res  = 2'd1;
          mode_d = MODE_IDLE;
          if (c == (hold_eq ? 8'h3d : 8'h3e)) begin
            res0  = '{kind: hold_eq ? KIND_EQUALS : KIND_ARROW, start: pstart_q,
                      length: 16'd2, last: 1'b0};
            pos_d = pos_inc;
          end else begin
            res0 = '{kind: hold_eq ? KIND_ASSIGN : KIND_MINUS, start: pstart_q,
                     length: 16'd1, last: 1'b0};
            fall = 1'b1;
          end
        end
        default: fall = 1'b1;
      endcase

      // Start a new token, or give a single-byte or end-of-text result, once the byte falls through to idle.
      if (fall) begin
        mode_d = MODE_IDLE;
        if (c == 8'h00) begin
          tok_new = '{kind: KIND_EOF, start: pos16, length: 16'd0, last: 1'b0};
          has_new = 1'b1;
          pos_d   = '0;
        end else if (is_space(c)) begin
          pos_d = pos_inc;
        end else if (is_alpha(c) || c == 8'h5f) begin
          mode_d      = MODE_IDENT;
          pstart_d    = pos16;
          plen_d      = 16'd1;
          prefix_d    = '0;
          prefix_d[0] = c;
          upper_d     = is_upper(c);
          pos_d       = pos_inc;
        end else if (is_digit(c)) begin
          mode_d   = MODE_INT;
          pstart_d = pos16;
          plen_d   = 16'd1;
          pos_d    = pos_inc;
        end else if (c == 8'h3d || c == 8'h2d) begin
          mode_d   = (c == 8'h3d) ? MODE_HOLD_EQ : MODE_HOLD_MINUS;
          pstart_d = pos16;
          plen_d   = 16'd1;
          pos_d    = pos_inc;
        end else if (punct[5]) begin
          tok_new = '{kind: punct[4:0], start: pos16, length: 16'd1, last: 1'b0};
          has_new = 1'b1;
          pos_d   = pos_inc;
        end else begin
          tok_new = '{kind: KIND_ERROR, start: pos16, length: 16'd1, last: 1'b0};
          has_new = 1'b1;
          mode_d  = MODE_HALTED;
          pos_d   = pos_inc;
        end
      end

      if (has_new) begin
        if (n_res == 2'd0) begin
          res0 = tok_new;
        end else begin
          res1 = tok_new;
        end
        n_res = n_res + 2'd1;
      end

      // Mark the final result of this byte.
      if (n_res == 2'd1) res0.last = 1'b1;
      if (n_res == 2'd2) res1.last = 1'b1;
    end
  end

  // Scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      pstart_q <= '0;
      plen_q   <= '0;
      prefix_q <= '0;
      upper_q  <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      prefix_q <= prefix_d;
      upper_q  <= upper_d;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + FIFO_AW'(n_res);
      if (out_xfer) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + FIFO_CW'(n_res) - FIFO_CW'(out_xfer);
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) fifo_q[wptr_q] <= res0;
    if (n_res == 2'd2) fifo_q[wptr_q + 1'b1] <= res1;
  end

  assign char_i.ready          = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));
  assign token_o.valid         = (cnt_q != '0);
  assign token_o.token_kind    = fifo_q[rptr_q].kind;
  assign token_o.token_start   = fifo_q[rptr_q].start;
  assign token_o.token_length  = fifo_q[rptr_q].length;
  assign token_o.last_of_step  = fifo_q[rptr_q].last;

endmodule

@@ src/stt_checker.sv @@
// Port-level checks for the source text tokenizer and their binding to the top level.
module stt_checker
  import stt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  out_kind_i,
  input logic [15:0] out_start_i,
  input logic [15:0] out_length_i,
  input logic        out_last_i
);

  // A stalled token holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
    $stable(out_start_i) && $stable(out_length_i) && $stable(out_last_i))
    else $error("stalled token changed");

  // End of text carries no bytes and is always the final result of its byte.
  a_eof_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_EOF |-> out_length_i == 16'd0 && out_last_i)
    else $error("end-of-text token malformed");

  // Two-character operators span two bytes and end their step.
  a_pair_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_EQUALS || out_kind_i == KIND_ARROW)
    |-> out_length_i == 16'd2 && out_last_i)
    else $error("two-character operator malformed");

  // An error token covers one byte and ends its step.
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_ERROR |-> out_length_i == 16'd1 && out_last_i)
    else $error("error token malformed");

  // An empty result queue never holds input off.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with no pending results");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (char_i.ready),
  .out_valid_i  (token_o.valid),
  .out_ready_i  (token_o.ready),
  .out_kind_i   (token_o.token_kind),
  .out_start_i  (token_o.token_start),
  .out_length_i (token_o.token_length),
  .out_last_i   (token_o.last_of_step)
);

@@ tb/sv/stt_tb_pkg.sv @@
// Token tracker for the tokenizer testbench: predicts tokens and checks the ones that arrive.
`timescale 1ns / 1ps
package stt_tb_pkg;
  import stt_pkg::*;

  typedef logic [7:0] char_q_t [$];

  // Scanner modes as the tracker follows them.
  typedef enum int {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_INT,
    SCAN_HOLD_EQ,
    SCAN_HOLD_MINUS,
    SCAN_HALTED
  } scan_mode_e;

  localparam string KEYWORDS [6] = '{"if", "else", "while", "for", "ret", "struct"};

  // Single-character punctuation in token kind order, starting at the semicolon.
  localparam string PUNCT_CHARS = ";(){}[],+*/!&@.<>";

  class token_tracker;
    token_t      due_tokens [$];
    int unsigned errors;

    scan_mode_e  mode;
    logic [15:0] position;
    logic [15:0] tok_start;
    logic [15:0] tok_length;
    logic [7:0]  prefix [KW_CHARS];
    bit          upper_first;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode        = SCAN_IDLE;
      position    = '0;
      tok_start   = '0;
      tok_length  = '0;
      upper_first = 1'b0;
      foreach (prefix[i]) prefix[i] = '0;
    endfunction

    // The byte position stops at its top value.
    function void bump();
      if (position != '1) position++;
    endfunction

    static function bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    static function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void add(logic [4:0] kind, logic [15:0] start, logic [15:0] len);
      token_t t;
      t.kind   = kind;
      t.start  = start;
      t.length = len;
      t.last   = 1'b0;
      due_tokens.push_back(t);
    endfunction

    // A finished identifier is a type, a keyword or a plain identifier.
    function logic [4:0] word_kind();
      string w;
      bit    same;
      if (upper_first) return KIND_TYPE;
      for (int k = 0; k < 6; k++) begin
        w = KEYWORDS[k];
        if (tok_length == w.len()) begin
          same = 1'b1;
          for (int i = 0; i < w.len(); i++) begin
            if (prefix[i] != w[i]) same = 1'b0;
          end
          if (same) return KIND_KW_IF + 5'(k);
        end
      end
      return KIND_IDENT;
    endfunction

    // Works out the tokens that one transferred byte causes.
    function void note_char(logic [7:0] c);
      logic [15:0] here;
      int unsigned made;
      int          pk;
      bit          eq;
      string       pc;
      here = position;
      made = 0;
      pk   = -1;
      pc   = PUNCT_CHARS;

      // After an unknown byte everything up to the end of the text is dropped.
      if (mode == SCAN_HALTED) begin
        if (c == 8'h00) clear();
        else bump();
        return;
      end

      // Close or extend whatever token is pending.
      case (mode)
        SCAN_IDENT: begin
          if (is_letter(c) || c == "_" || c == "@") begin
            if (tok_length < KW_CHARS) prefix[tok_length] = c;
            if (tok_length != LEN_MAX) tok_length++;
            bump();
            return;
          end
          add(word_kind(), tok_start, tok_length);
          made++;
          mode = SCAN_IDLE;
        end
        SCAN_INT: begin
          if (is_digit(c)) begin
            if (tok_length != LEN_MAX) tok_length++;
            bump();
            return;
          end
          add(KIND_INT, tok_start, tok_length);
          made++;
          mode = SCAN_IDLE;
        end
        SCAN_HOLD_EQ, SCAN_HOLD_MINUS: begin
          eq   = (mode == SCAN_HOLD_EQ);
          mode = SCAN_IDLE;
          if ((eq && c == "=") || (!eq && c == ">")) begin
            add(eq ? KIND_EQUALS : KIND_ARROW, tok_start, 16'd2);
            bump();
            due_tokens[due_tokens.size() - 1].last = 1'b1;
            return;
          end
          add(eq ? KIND_ASSIGN : KIND_MINUS, tok_start, 16'd1);
          made++;
        end
        default: begin
          mode = SCAN_IDLE;
        end
      endcase

      for (int i = 0; i < pc.len(); i++) begin
        if (c == pc[i]) pk = i;
      end

      // Classify the byte itself.
      if (c == 8'h00) begin
        add(KIND_EOF, here, 16'd0);
        made++;
        clear();
      end else if (c == " " || c == 8'h0a || c == 8'h09) begin
        bump();
      end else if (is_letter(c) || c == "_") begin
        mode        = SCAN_IDENT;
        tok_start   = here;
        tok_length  = 16'd1;
        foreach (prefix[i]) prefix[i] = '0;
        prefix[0]   = c;
        upper_first = (c >= "A" && c <= "Z");
        bump();
      end else if (is_digit(c)) begin
        mode       = SCAN_INT;
        tok_start  = here;
        tok_length = 16'd1;
        bump();
      end else if (c == "=" || c == "-") begin
        mode       = (c == "=") ? SCAN_HOLD_EQ : SCAN_HOLD_MINUS;
        tok_start  = here;
        tok_length = 16'd1;
        bump();
      end else if (pk >= 0) begin
        add(KIND_SEMI + 5'(pk), here, 16'd1);
        made++;
        bump();
      end else begin
        add(KIND_ERROR, here, 16'd1);
        made++;
        mode = SCAN_HALTED;
        bump();
      end

      if (made > 0) due_tokens[due_tokens.size() - 1].last = 1'b1;
    endfunction

    // Compares one transferred token with the oldest prediction.
    function void check_token(logic [4:0] kind, logic [15:0] start, logic [15:0] len,
                              logic last);
      token_t want;
      if (due_tokens.size() == 0) begin
        $error("unexpected token: kind %0d start %0d length %0d", kind, start, len);
        errors++;
        return;
      end
      want = due_tokens.pop_front();
      if (kind !== want.kind) begin
        $error("token_kind: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (start !== want.start) begin
        $error("token_start: expected %0d, actual %0d", want.start, start);
        errors++;
      end
      if (len !== want.length) begin
        $error("token_length: expected %0d, actual %0d", want.length, len);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_step: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ tb/sv/tb_source_text_tokenizer.sv @@
// Top level of the tokenizer testbench: clock, reset, byte sender, token receiver and checks.
`timescale 1ns / 1ps
module tb_source_text_tokenizer;
  import stt_pkg::*;
  import stt_tb_pkg::*;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_CHARS = 1200;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_TOGGLE, RX_HOLD} rx_style_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  stt_char_if  char_bus ();
  stt_token_if token_bus ();

  source_text_tokenizer u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_bus),
    .token_o (token_bus)
  );

  token_tracker tracker = new();
  int unsigned  stall_count = 0;
  int unsigned  burst_left  = 0;

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void append(ref char_q_t t, input string s);
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
  endfunction

  function automatic logic [7:0] letter(input bit upper);
    return upper ? 8'("A" + $urandom_range(25, 0)) : 8'("a" + $urandom_range(25, 0));
  endfunction

  function automatic logic [7:0] blank();
    case ($urandom_range(3, 0))
      0:       return 8'h0a;
      1:       return 8'h09;
      default: return " ";
    endcase
  endfunction

  // Tail bytes of an identifier; a digit now and then splits it into an integer.
  function automatic logic [7:0] word_tail();
    case ($urandom_range(9, 0))
      0:       return "_";
      1:       return "@";
      2:       return 8'("0" + $urandom_range(9, 0));
      3:       return letter(1'b1);
      default: return letter(1'b0);
    endcase
  endfunction

  // One text of mostly well-formed tokens with random content, closed by a zero byte.
  function automatic char_q_t random_text();
    char_q_t t;
    int      pick;
    string   pc;
    pc = PUNCT_CHARS;
    repeat ($urandom_range(25, 0)) begin
      pick = $urandom_range(99, 0);
      if (pick < 3) begin
        t.push_back(8'($urandom_range(255, 1)));
      end else if (pick < 18) begin
        append(t, KEYWORDS[$urandom_range(5, 0)]);
        if ($urandom_range(4, 0) == 0) t.push_back(letter(1'b0));
      end else if (pick < 40) begin
        case ($urandom_range(2, 0))
          0:       t.push_back(letter(1'b1));
          1:       t.push_back(letter(1'b0));
          default: t.push_back("_");
        endcase
        repeat ($urandom_range(9, 0)) t.push_back(word_tail());
      end else if (pick < 55) begin
        repeat ($urandom_range(6, 1)) t.push_back(8'("0" + $urandom_range(9, 0)));
      end else if (pick < 75) begin
        t.push_back(pc[$urandom_range(16, 0)]);
      end else if (pick < 90) begin
        case ($urandom_range(3, 0))
          0:       append(t, "=");
          1:       append(t, "==");
          2:       append(t, "-");
          default: append(t, "->");
        endcase
      end else begin
        repeat ($urandom_range(4, 1)) t.push_back(blank());
      end
      if ($urandom_range(9, 0) < 7) t.push_back(blank());
    end
    t.push_back(8'h00);
    return t;
  endfunction

  // Offers the bytes in bursts; each byte is held until its transfer.
  task automatic send_text(input char_q_t text, input bit with_gaps);
    int gap;
    foreach (text[i]) begin
      if (with_gaps && burst_left == 0) begin
        gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        repeat (gap) begin
          @(negedge clk_i);
          char_bus.valid     <= 1'b0;
          char_bus.char_code <= 8'($urandom);
        end
        burst_left = $urandom_range(40, 1);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clk_i);
      char_bus.valid     <= 1'b1;
      char_bus.char_code <= text[i];
      do @(posedge clk_i); while (!char_bus.ready);
    end
  endtask

  // Receiver: phases of different stall patterns, with a long hold-off now and then.
  initial begin : receiver
    int        span;
    int        phase;
    rx_style_e style;
    token_bus.ready <= 1'b0;
    @(posedge rst_ni);
    phase = 0;
    forever begin
      if (phase % 12 == 3) begin
        style = RX_HOLD;
        span  = $urandom_range(300, 150);
      end else begin
        style = rx_style_e'($urandom_range(3, 0));
        span  = $urandom_range(200, 10);
      end
      repeat (span) begin
        @(negedge clk_i);
        case (style)
          RX_ALWAYS: token_bus.ready <= 1'b1;
          RX_MOSTLY: token_bus.ready <= ($urandom_range(3, 0) != 0);
          RX_SPARSE: token_bus.ready <= ($urandom_range(3, 0) == 0);
          RX_TOGGLE: token_bus.ready <= ~token_bus.ready;
          default:   token_bus.ready <= 1'b0;
        endcase
      end
      phase++;
    end
  end

  // Predict on every byte transfer, check on every token transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (char_bus.valid && char_bus.ready) tracker.note_char(char_bus.char_code);
      if (token_bus.valid && token_bus.ready) begin
        tracker.check_token(token_bus.token_kind, token_bus.token_start,
                            token_bus.token_length, token_bus.last_of_step);
      end
      if ((char_bus.valid && char_bus.ready) || (token_bus.valid && token_bus.ready)) begin
        stall_count <= 0;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  // Ends a run in which nothing moves for too long.
  initial begin : watchdog
    wait (stall_count >= STALL_LIMIT);
    $display("tb_source_text_tokenizer NOT OK");
    $finish;
  end

  initial begin : stimulus
    char_q_t     text;
    int unsigned sent;
    char_bus.valid     <= 1'b0;
    char_bus.char_code <= 8'h00;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: keyword, held '=' and '-', identifier into digit, type name,
    // unknown bytes with the halt that follows, end of text in several states.
    text = {};
    text.push_back(8'h00);
    append(text, "if=a1 -> ==;X_@");
    text.push_back(8'hFF);
    append(text, "q");
    text.push_back(8'h00);
    append(text, "-");
    text.push_back(8'h00);
    text.push_back(8'h0d);
    text.push_back(8'h00);
    append(text, "\"");
    text.push_back(8'h00);
    send_text(text, 1'b1);

    // Random texts.
    sent = 0;
    while (sent < RANDOM_CHARS) begin
      text = random_text();
      send_text(text, 1'b1);
      sent += text.size();
    end
    @(negedge clk_i);
    char_bus.valid <= 1'b0;

    while (tracker.due_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.errors == 0) begin
      $display("tb_source_text_tokenizer OK");
    end else begin
      $display("tb_source_text_tokenizer NOT OK");
    end
    $finish;
  end

endmodule
